>>> hdl/sim_pkg.sv
`timescale 1ns / 1ps
package sim_pkg;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_EMERG  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_BEGIN  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_SAFE  = 3'd0,
    ST_STOP  = 3'd1,
    ST_TILT  = 3'd2,
    ST_LIFT  = 3'd3,
    ST_EMERG = 3'd4
  } safety_state_e;

  typedef enum logic [1:0] {
    REG_TILT_ENABLE    = 2'd0,
    REG_TILT_THRESHOLD = 2'd1,
    REG_DEBOUNCE_MS    = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic        TiltEnableRst    = 1'b0;
  localparam logic [14:0] TiltThresholdRst = 15'd3000;
  localparam logic [15:0] DebounceMsRst    = 16'd50;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        now_ms;
    logic               stop_pin;
    logic               lift_raw;
    logic signed [15:0] pitch_cdeg;
  } in_item_t;

  typedef struct packed {
    logic [2:0] safety_state;
    logic       stop_pressed;
    logic       lifted;
    logic       tilted;
  } out_item_t;

  typedef struct packed {
    logic        prev_raw;
    logic        stable;
    logic        flag;
    logic [31:0] stamp;
  } debounce_t;

endpackage

>>> hdl/safety_interlock_monitor_core.sv
`timescale 1ns / 1ps
// Safety interlock monitor core.
// Input items arrive on in_valid_i/in_ready_o with in_data_i; a transfer takes
// place when valid and ready are both high at a rising clock edge. Every input
// item yields exactly one result on out_valid_o/out_ready_i with out_data_o.
// A sample item updates the two pin debouncers and the tilt flag and then picks
// the safety state by priority; the other function codes latch, clear or re-arm.
// An accepted item is held in the input register; its state update and result
// are written into the result register when it advances. One item per cycle is
// sustained while the receiver takes results: the input register drains into
// the result register whenever that is empty or being taken. When the receiver
// stalls, the result holds and the input register keeps one more item;
// in_ready_o drops only once both are full. The configuration port writes tilt
// enable, tilt threshold and debounce window by index on cfg_we_i; the user is
// to use it only while no item is in flight, which the block does not enforce.
// Reset (rst_ni low) empties both registers, clears all debouncer and tilt state,
// sets the safety state to safe and loads the default configuration.
module safety_interlock_monitor_core
  import sim_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic          tilt_enable_q;
  logic [14:0]   tilt_threshold_q;
  logic [15:0]   debounce_ms_q;

  logic          s1_valid_q;
  in_item_t      s1_data_q;
  logic          out_valid_q;
  out_item_t     out_data_q;
  out_item_t     out_data_d;

  safety_state_e state_q, state_d;
  debounce_t     stop_q, stop_d;
  debounce_t     lift_q, lift_d;
  logic          tilt_q, tilt_d;

  logic          advance;
  logic signed [16:0] pitch_ext;
  logic [16:0]   pitch_mag;

  function automatic debounce_t debounce_step(debounce_t cur, logic reading,
                                              logic [31:0] now, logic [15:0] window);
    debounce_t   nxt;
    logic [31:0] elapsed;
    nxt     = cur;
    elapsed = now - cur.stamp;
    if (elapsed > {16'd0, window}) begin
      if (reading != cur.prev_raw) begin
        nxt.stamp  = now;
        nxt.stable = reading;
      end
      nxt.flag = ~nxt.stable;
    end
    nxt.prev_raw = reading;
    return nxt;
  endfunction

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  assign pitch_ext = {s1_data_q.pitch_cdeg[15], s1_data_q.pitch_cdeg};
  assign pitch_mag = pitch_ext[16] ? 17'(-pitch_ext) : 17'(pitch_ext);

  always_comb begin
    state_d = state_q;
    stop_d  = stop_q;
    lift_d  = lift_q;
    tilt_d  = tilt_q;
    case (func_e'(s1_data_q.func))
      FUNC_SAMPLE: begin
        tilt_d = tilt_enable_q && (pitch_mag > {2'b00, tilt_threshold_q});
        lift_d = debounce_step(lift_q, s1_data_q.lift_raw, s1_data_q.now_ms,
                               debounce_ms_q);
        stop_d = debounce_step(stop_q, s1_data_q.stop_pin, s1_data_q.now_ms,
                               debounce_ms_q);
        if (state_q == ST_EMERG) begin
          state_d = ST_EMERG;
        end else if (stop_d.flag) begin
          state_d = ST_STOP;
        end else if (tilt_d) begin
          state_d = ST_TILT;
        end else if (lift_d.flag) begin
          state_d = ST_LIFT;
        end else begin
          state_d = ST_SAFE;
        end
      end
      FUNC_EMERG: begin
        state_d = ST_EMERG;
      end
      FUNC_CLEAR: begin
        if (state_q == ST_EMERG) begin
          state_d = ST_SAFE;
        end
      end
      default: begin
        state_d         = ST_SAFE;
        stop_d.prev_raw = s1_data_q.stop_pin;
        lift_d.prev_raw = s1_data_q.lift_raw;
        stop_d.stamp    = s1_data_q.now_ms;
        lift_d.stamp    = s1_data_q.now_ms;
      end
    endcase
    out_data_d.safety_state = state_d;
    out_data_d.stop_pressed = stop_d.flag;
    out_data_d.lifted       = lift_d.flag;
    out_data_d.tilted       = tilt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_enable_q    <= TiltEnableRst;
      tilt_threshold_q <= TiltThresholdRst;
      debounce_ms_q    <= DebounceMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TILT_ENABLE:    tilt_enable_q    <= cfg_wdata_i[0];
        REG_TILT_THRESHOLD: tilt_threshold_q <= cfg_wdata_i[14:0];
        REG_DEBOUNCE_MS:    debounce_ms_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_SAFE;
      stop_q      <= '0;
      lift_q      <= '0;
      tilt_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        stop_q      <= stop_d;
        lift_q      <= lift_d;
        tilt_q      <= tilt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_stall_both_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a register is empty");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.safety_state <= ST_EMERG))
    else $error("result carries an undefined safety state");

  a_emerg_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_data_q.func == FUNC_EMERG) |=>
      (out_valid_o && out_data_o.safety_state == ST_EMERG))
    else $error("emergency transfer did not latch the emergency state");

  a_begin_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_data_q.func == FUNC_BEGIN) |=>
      (out_valid_o && out_data_o.safety_state == ST_SAFE && state_q == ST_SAFE))
    else $error("re-arm transfer did not return to the safe state");
`endif

endmodule
